// ===== design/png_scanline_unfilter_macros.svh =====
// Assertion macros shared by the unfilter RTL.
// Each macro expects clk and rst_n in scope.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef SYNTHESIS

`define PSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psu assertion failed");

`define PSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psu assertion failed");

`else

`define PSU_ASSERT_IMP(lbl, ante, cons)

`define PSU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/psu_pkg.sv =====
package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF = 8192;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

endpackage

// ===== design/png_scanline_unfilter.sv =====
// Pipeline: an accepted item passes through the stage 1 register and then the output register.
// Throughput: one item per cycle, held back only by out_ready; filter bytes and dropped
// bytes give no result but are still accepted at the same rate.
// Line store: one single-port-read, single-port-write memory of MAX_ROW_BYTES bytes.
// Reset (rst_n low, synchronous) clears control state; the line store is not cleared.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_image_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_row_last,
  output logic        out_bad_filter,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psu_pkg::*;

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LW = $clog2(MAX_ROW_BYTES + 1);

  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_BPP        = 1'b1;

  typedef struct packed {
    filt_t      filter;
    logic       err;
    logic       last;
    logic       top;
    logic       has_left;
    logic [1:0] back;
    logic [1:0] slot;
  } s1_ctrl_t;

  // configuration
  logic [13:0] row_length_r;
  logic [2:0]  bpp_r;
  logic        cfg_we;

  // row state
  logic [AW-1:0] col_r, col_nxt;
  logic          in_row_r, in_row_nxt;
  logic          top_row_r, top_row_nxt;
  logic          halted_r, halted_nxt;
  filt_t         filter_r, filter_nxt;

  // stage 1
  logic          s1_valid_r, s1_valid_nxt;
  s1_ctrl_t      s1_r, s1_nxt;
  logic [AW-1:0] s1_col_r;
  logic [7:0]    s1_byte_r;
  logic          s1_load;
  logic          s1_adv;
  logic          ld_err;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_row_last_r;
  logic       out_bad_filter_r;
  logic       out_free;

  // line store
  logic [7:0]    line_mem [MAX_ROW_BYTES];
  logic [7:0]    rd_data_r;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;

  logic [7:0] left_hist_r [4];
  logic [7:0] above_hist_r [4];

  logic          in_fire;
  logic [LW-1:0] eff_len;
  logic [2:0]    eff_bpp;
  logic [31:0]   col32;
  logic          st_halted;
  logic          st_in_row;
  logic          st_top;
  logic          row_end;

  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [7:0] recon;

  // APB
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LENGTH: prdata = {18'd0, row_length_r};
      REG_BPP:        prdata = {29'd0, bpp_r};
      default:        prdata = 32'd0;
    endcase
  end

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_row_last   = out_row_last_r;
  assign out_bad_filter = out_bad_filter_r;

  // effective register values
  always_comb begin
    if (row_length_r == 14'd0) begin
      eff_len = LW'(1);
    end else if (32'(row_length_r) > 32'(MAX_ROW_BYTES)) begin
      eff_len = LW'(MAX_ROW_BYTES);
    end else begin
      eff_len = LW'(row_length_r);
    end
    if (bpp_r == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (bpp_r > 3'd4) begin
      eff_bpp = 3'd4;
    end else begin
      eff_bpp = bpp_r;
    end
  end

  // accept-side decode
  always_comb begin
    col32     = 32'(col_r);
    st_halted = in_image_start ? 1'b0 : halted_r;
    st_in_row = in_image_start ? 1'b0 : in_row_r;
    st_top    = in_image_start ? 1'b1 : top_row_r;
    row_end   = (LW'(col_r) + LW'(1)) >= eff_len;

    col_nxt     = col_r;
    in_row_nxt  = st_in_row;
    top_row_nxt = st_top;
    halted_nxt  = st_halted;
    filter_nxt  = filter_r;
    s1_load     = 1'b0;
    ld_err      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = col_r;

    s1_nxt          = '0;
    s1_nxt.filter   = filter_r;
    s1_nxt.top      = st_top;
    s1_nxt.has_left = col32 >= 32'(eff_bpp);
    s1_nxt.back     = col32[1:0] - eff_bpp[1:0];
    s1_nxt.slot     = col32[1:0];
    s1_nxt.last     = row_end;

    if (in_image_start) begin
      col_nxt = '0;
    end
    if (in_fire && !st_halted) begin
      if (!st_in_row) begin
        if (in_byte > 8'(FILT_PAETH)) begin
          // unknown filter: one error item, then drop until next image start
          halted_nxt  = 1'b1;
          s1_load     = 1'b1;
          ld_err      = 1'b1;
          s1_nxt.err  = 1'b1;
          s1_nxt.last = 1'b0;
        end else begin
          filter_nxt = filt_t'(in_byte[2:0]);
          in_row_nxt = 1'b1;
          col_nxt    = '0;
        end
      end else begin
        s1_load = 1'b1;
        mem_re  = 1'b1;
        if (row_end) begin
          in_row_nxt  = 1'b0;
          col_nxt     = '0;
          top_row_nxt = 1'b0;
        end else begin
          col_nxt = AW'(col32 + 32'd1);
        end
      end
    end

    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // stage 1 neighbors
  always_comb begin
    nb_a = s1_r.has_left ? left_hist_r[s1_r.back] : 8'd0;
    nb_b = s1_r.top ? 8'd0 : rd_data_r;
    nb_c = (s1_r.has_left && !s1_r.top) ? above_hist_r[s1_r.back] : 8'd0;
  end

  psu_predict u_predict (
    .filter (s1_r.filter),
    .raw    (s1_byte_r),
    .a      (nb_a),
    .b      (nb_b),
    .c      (nb_c),
    .recon  (recon)
  );

  assign mem_we    = s1_adv && !s1_r.err;
  assign mem_waddr = s1_col_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= 14'd1;
      bpp_r        <= 3'd1;
      col_r        <= '0;
      in_row_r     <= 1'b0;
      top_row_r    <= 1'b1;
      halted_r     <= 1'b0;
      filter_r     <= FILT_NONE;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[2])
          REG_ROW_LENGTH: row_length_r <= pwdata[13:0];
          REG_BPP:        bpp_r        <= pwdata[2:0];
          default:        ;
        endcase
      end
      if (in_fire) begin
        col_r     <= col_nxt;
        in_row_r  <= in_row_nxt;
        top_row_r <= top_row_nxt;
        halted_r  <= halted_nxt;
        filter_r  <= filter_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r      <= s1_nxt;
      s1_col_r  <= col_r;
      s1_byte_r <= in_byte;
    end
    if (s1_adv) begin
      out_byte_r       <= s1_r.err ? 8'd0 : recon;
      out_row_last_r   <= s1_r.last && !s1_r.err;
      out_bad_filter_r <= s1_r.err;
    end
  end

  // recent left and above bytes, indexed by column mod 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        left_hist_r[i]  <= 8'd0;
        above_hist_r[i] <= 8'd0;
      end
    end else if (mem_we) begin
      left_hist_r[s1_r.slot]  <= recon;
      above_hist_r[s1_r.slot] <= nb_b;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= recon;
    end
  end

  // hold read data while stage 1 stalls
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= line_mem[mem_raddr];
    end
  end

  `PSU_ASSERT_IMP(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr)
  `PSU_ASSERT_IMP(a_err_clean, out_valid_r && out_bad_filter_r, out_byte_r == 8'd0 && !out_row_last_r)
  `PSU_ASSERT_IMP(a_halt_no_row, halted_r, !in_row_r)
  `PSU_ASSERT_NXT(a_err_halts, in_fire && ld_err, halted_r && s1_valid_r && s1_r.err)

endmodule

// ===== design/psu_predict.sv =====
module psu_predict (
  input  psu_pkg::filt_t filter,
  input  logic [7:0]     raw,
  input  logic [7:0]     a,
  input  logic [7:0]     b,
  input  logic [7:0]     c,
  output logic [7:0]     recon
);
  import psu_pkg::*;

  logic [8:0] sum_ab;
  logic [9:0] d_pa;
  logic [9:0] d_pb;
  logic [9:0] d_pc;
  logic [9:0] pa;
  logic [9:0] pb;
  logic [9:0] pc;
  logic [7:0] paeth;
  logic [7:0] pred;

  // Paeth distances: |b - c|, |a - c|, |a + b - 2c| in 10-bit two's complement
  always_comb begin
    sum_ab = {1'b0, a} + {1'b0, b};
    d_pa   = {2'b00, b} - {2'b00, c};
    d_pb   = {2'b00, a} - {2'b00, c};
    d_pc   = {1'b0, sum_ab} - {1'b0, c, 1'b0};
    pa     = d_pa[9] ? (~d_pa + 10'd1) : d_pa;
    pb     = d_pb[9] ? (~d_pb + 10'd1) : d_pb;
    pc     = d_pc[9] ? (~d_pc + 10'd1) : d_pc;
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    case (filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    recon = raw + pred;
  end

endmodule

// ===== dv/png_scanline_unfilter_tb.sv =====
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
  import psu_pkg::*;

  localparam int LINE_BYTES = MAX_ROW_BYTES_DEF;
  localparam int FLOOD_ROW_BYTES = 64;
  localparam logic [2:0] ADDR_ROW_LENGTH = 3'd0;
  localparam logic [2:0] ADDR_PIXEL_BYTES = 3'd4;
  localparam int RANDOM_PHASES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       image_start;
  } stream_byte_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       row_last;
    logic       bad_filter;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_image_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_row_last;
  logic        out_bad_filter;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_row_last   (out_row_last),
    .out_bad_filter (out_bad_filter),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Unfilter state mirrored from the block
  logic [13:0] row_len_set = 14'd1;
  logic [2:0]  pixel_bytes_set = 3'd1;
  logic [7:0]  line_store [LINE_BYTES];
  logic [7:0]  left_hist [4];
  logic [7:0]  above_left_hist [4];
  int          column = 0;
  logic        in_row = 1'b0;
  filt_t       row_filt = FILT_NONE;
  logic        top_row = 1'b1;
  logic        halted = 1'b0;
  int          store_fill = 0;

  stream_byte_t stream_q[$];
  sample_t      expected_samples[$];
  int           mismatches = 0;
  logic         flood_on = 1'b0;
  logic         hold_off = 1'b0;
  int           tx_gap = 0;
  int           tx_calm = 0;
  int           rx_gap = 0;
  int           rx_calm = 0;

  int phase_row_len [RANDOM_PHASES] = '{5, 0, 16, 7, 12, 1, 9, 4};
  int phase_pix     [RANDOM_PHASES] = '{2, 0, 4, 3, 7, 4, 1, 1};

  initial begin
    for (int i = 0; i < 4; i++) begin
      left_hist[i] = '0;
      above_left_hist[i] = '0;
    end
  end

  function automatic int paeth_pick(input int a, input int b, input int c);
    int est, pa, pb, pc;
    est = a + b - c;
    pa = (est > a) ? est - a : a - est;
    pb = (est > b) ? est - b : b - est;
    pc = (est > c) ? est - c : c - est;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advance the mirrored state by one stream byte, queue any sample it yields
  function automatic void unfilter_step(input logic [7:0] data, input logic start);
    int len, bpp, col, back, a, b, c, pred;
    logic [7:0] val;
    logic has_left, last;
    sample_t res;
    if (start) begin
      top_row = 1'b1;
      halted = 1'b0;
      in_row = 1'b0;
      column = 0;
    end
    if (halted) return;
    if (!in_row) begin
      if (data > 8'(FILT_PAETH)) begin
        halted = 1'b1;
        res = '{8'h00, 1'b0, 1'b1};
        expected_samples.push_back(res);
      end else begin
        row_filt = filt_t'(data[2:0]);
        column = 0;
        in_row = 1'b1;
      end
      return;
    end
    len = (row_len_set == 0) ? 1 : ((row_len_set > LINE_BYTES) ? LINE_BYTES : row_len_set);
    bpp = (pixel_bytes_set == 0) ? 1 : ((pixel_bytes_set > 4) ? 4 : pixel_bytes_set);
    col = column;
    has_left = (col >= bpp);
    back = (col - bpp) & 3;
    a = has_left ? left_hist[back] : 0;
    b = (!top_row && col < LINE_BYTES) ? line_store[col] : 0;
    c = (!top_row && has_left) ? above_left_hist[back] : 0;
    case (row_filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) / 2;
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 0;
    endcase
    val = 8'(int'(data) + pred);
    left_hist[col & 3] = val;
    above_left_hist[col & 3] = 8'(b);
    if (col < LINE_BYTES) begin
      line_store[col] = val;
      if (col + 1 > store_fill) store_fill = col + 1;
    end
    last = (col + 1 >= len);
    if (last) begin
      in_row = 1'b0;
      column = 0;
      top_row = 1'b0;
    end else begin
      column = col + 1;
    end
    res = '{val, last, 1'b0};
    expected_samples.push_back(res);
  endfunction

  // True when the next plain data byte would read a line store entry never written
  function automatic logic store_gap_ahead();
    return in_row && !halted && !top_row && column >= store_fill;
  endfunction

  function automatic void offer(input logic [7:0] data, input logic start);
    stream_byte_t it;
    it = '{data, start};
    stream_q.push_back(it);
    unfilter_step(data, start);
  endfunction

  function automatic logic [7:0] pick_filter();
    return 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void random_stream(input int count);
    int made;
    made = 0;
    while (made < count) begin
      if (halted) begin
        // junk while halted is dropped; most of the time restart the image
        if ($urandom_range(0, 3) == 0) begin
          offer(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          offer(($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255)) : pick_filter(), 1'b1);
          made++;
        end
      end else if (!in_row) begin
        offer(($urandom_range(0, 19) == 0) ? 8'($urandom_range(5, 255)) : pick_filter(),
              $urandom_range(0, 7) == 0);
        made++;
      end else if (store_gap_ahead() || $urandom_range(0, 49) == 0) begin
        offer(pick_filter(), 1'b1);
        made++;
      end else begin
        offer(8'($urandom_range(0, 255)), 1'b0);
        made++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (stream_q.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_ROW_LENGTH:  row_len_set = value[13:0];
      ADDR_PIXEL_BYTES: pixel_bytes_set = value[2:0];
      default: ;
    endcase
  endtask

  // Input driver
  always @(posedge clk) begin
    stream_byte_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (stream_q.size() > 0) begin
        it = stream_q.pop_front();
        in_byte <= it.data;
        in_image_start <= it.image_start;
        in_valid <= 1'b1;
        tx_gap = idle_len(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample: byte %02h last %0b bad %0b",
                     out_byte, out_row_last, out_bad_filter);
        end else begin
          want = expected_samples.pop_front();
          if (out_byte !== want.sample || out_row_last !== want.row_last ||
              out_bad_filter !== want.bad_filter) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample differs: exp byte %02h last %0b bad %0b, got %02h %0b %0b",
                       want.sample, want.row_last, want.bad_filter,
                       out_byte, out_row_last, out_bad_filter);
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap = idle_len(rx_calm);
      end
    end
  end

  // Hold off the receiver during the long rows so the input side backs up
  initial begin
    while (!flood_on) @(posedge clk);
    repeat (10) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("png_scanline_unfilter: mismatch");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    reg_write(ADDR_ROW_LENGTH, 32'd3);
    reg_write(ADDR_PIXEL_BYTES, 32'd1);

    // every filter on three-byte rows, then bad filters and restarts
    offer(8'(FILT_NONE), 1'b1);
    offer(8'h00, 1'b0); offer(8'hFF, 1'b0); offer(8'h80, 1'b0);
    offer(8'(FILT_SUB), 1'b0);
    offer(8'hFF, 1'b0); offer(8'h01, 1'b0); offer(8'h80, 1'b0);
    offer(8'(FILT_UP), 1'b0);
    offer(8'h7F, 1'b0); offer(8'h00, 1'b0); offer(8'hFF, 1'b0);
    offer(8'(FILT_AVG), 1'b0);
    offer(8'h01, 1'b0); offer(8'hFE, 1'b0); offer(8'h55, 1'b0);
    offer(8'(FILT_PAETH), 1'b0);
    offer(8'hFF, 1'b0); offer(8'h80, 1'b0); offer(8'h00, 1'b0);
    offer(8'h05, 1'b0);
    offer(8'hAA, 1'b0);
    offer(8'(FILT_PAETH), 1'b1);
    offer(8'h12, 1'b0); offer(8'h34, 1'b0);
    offer(8'hFF, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      reg_write(ADDR_ROW_LENGTH, 32'(phase_row_len[p]));
      reg_write(ADDR_PIXEL_BYTES, 32'(phase_pix[p]));
      random_stream(55);
    end

    // two long rows: the second reads every entry the first wrote
    wait_idle();
    reg_write(ADDR_ROW_LENGTH, 32'(FLOOD_ROW_BYTES));
    reg_write(ADDR_PIXEL_BYTES, 32'd3);
    flood_on = 1'b1;
    offer(8'(FILT_SUB), 1'b1);
    for (int i = 0; i < FLOOD_ROW_BYTES; i++) offer(8'($urandom_range(0, 255)), 1'b0);
    offer(8'(FILT_PAETH), 1'b0);
    for (int i = 0; i < FLOOD_ROW_BYTES; i++) offer(8'($urandom_range(0, 255)), 1'b0);

    // saturating register values
    wait_idle();
    reg_write(ADDR_ROW_LENGTH, 32'h3FFF);
    reg_write(ADDR_PIXEL_BYTES, 32'd6);
    random_stream(50);

    wait_idle();
    repeat (10) @(posedge clk);
    mismatches += expected_samples.size();
    if (mismatches == 0) begin
      $display("png_scanline_unfilter: match");
    end else begin
      $display("png_scanline_unfilter: mismatch");
    end
    $finish;
  end

endmodule

// ===== png_scanline_unfilter.f =====
+incdir+design
design/psu_pkg.sv
design/psu_predict.sv
design/png_scanline_unfilter.sv
dv/png_scanline_unfilter_tb.sv
